// ===== rtl/core/hst_pkg.sv =====
// ----------------------------------------------------------------------------
// hst_pkg
// Shared types for the histogram statistics block: the channel payloads and
// the controller states.
// ----------------------------------------------------------------------------
package hst_pkg;

	typedef struct packed {
		logic [30:0] bin_count;
		logic        last_bin;
	} bin_item_t;

	typedef struct packed {
		logic [7:0]  min_value;
		logic [7:0]  max_value;
		logic [15:0] mean_fixed;
		logic [8:0]  median_doubled;
		logic [7:0]  mode_value;
		logic        empty_res;
	} stats_item_t;

	localparam int unsigned MEAN_FRAC_BITS = 8;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_DRAIN,
		ST_CALC,
		ST_FINISH
	} hst_state_t;

endpackage

// ===== rtl/core/hst_stream_if.sv =====
// ----------------------------------------------------------------------------
// hst_stream_if
// Valid/ready stream channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface hst_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/histogram_statistics.sv =====
// ----------------------------------------------------------------------------
// histogram_statistics
// Min, max, mean, median and mode of a histogram delivered bin by bin.
// ----------------------------------------------------------------------------
// Usage: bin counts arrive on the hist channel, one transfer per bin, from
// bin zero upward; last_bin marks the final bin. Loading takes one bin per
// cycle, each count going into an internal bin memory while running totals
// (count, weighted sum, lowest/highest nonzero bin, mode) are updated.
// After the last bin, the channel is held off while a drain state completes
// the totals, then a median pass reads the stored bins back (one memory read
// per cycle) while a radix-2 divider forms the mean; the result is
// registered once both have finished.
// Loading of the next histogram starts at once, even while that result waits
// to be taken; if the receiver stalls, the following result waits in its
// final state, with the hist channel held off, until the output register
// frees up.
// Reset clears all totals and the controller; memory contents are not reset
// and are rewritten before they are read. An all-zero histogram gives
// empty_res set and all other fields zero.
// ----------------------------------------------------------------------------
module histogram_statistics
	import hst_pkg::*;
#(
	parameter int unsigned NUM_BINS   = 256,
	parameter int unsigned COUNT_BITS = 31
) (
	input  logic         clk,
	input  logic         arst_n,
	hst_stream_if.sink   hist,
	hst_stream_if.source stats
);

	localparam int unsigned IDX_W = $clog2(NUM_BINS);
	localparam int unsigned NB_W  = $clog2(NUM_BINS + 1);
	localparam int unsigned TC_W  = COUNT_BITS + IDX_W;
	localparam int unsigned WS_W  = COUNT_BITS + 2 * IDX_W;
	localparam int unsigned WD    = WS_W + MEAN_FRAC_BITS;
	localparam int unsigned DI_W  = $clog2(WD);

	hst_state_t state_q, state_d;

	logic [COUNT_BITS-1:0] mem [NUM_BINS];

	logic [31:0]           cnt_ext;
	logic [COUNT_BITS-1:0] cnt_in;
	logic                  accept;
	logic                  store_en;
	logic [IDX_W-1:0]      wr_idx;

	logic [NB_W-1:0]             next_q;
	logic                        v_s1;
	logic [COUNT_BITS-1:0]       cnt_s1;
	logic [IDX_W-1:0]            idx_s1;
	logic [IDX_W+COUNT_BITS-1:0] prod_s1;

	logic [TC_W-1:0]       total_q;
	logic [WS_W-1:0]       wsum_q;
	logic                  any_q;
	logic [IDX_W-1:0]      min_q;
	logic [IDX_W-1:0]      max_q;
	logic [IDX_W-1:0]      mode_q;
	logic [COUNT_BITS-1:0] mode_cnt_q;

	logic [DI_W-1:0] div_idx_q;
	logic            div_done_q;
	logic [TC_W-1:0] rem_q;
	logic [15:0]     quo_q;
	logic [WD-1:0]   dvd;
	logic [TC_W:0]   rem_sh;
	logic            q_bit;

	logic [NB_W-1:0]       rd_cnt_q;
	logic                  rd_en;
	logic                  rd_v_s1;
	logic [IDX_W-1:0]      rd_idx_s1;
	logic [COUNT_BITS-1:0] rd_data_s1;
	logic [TC_W-1:0]       cum_q;
	logic [TC_W-1:0]       cum_nxt;
	logic [TC_W-1:0]       rank_lo;
	logic [TC_W-1:0]       rank_hi;
	logic                  fa_q, fb_q;
	logic [IDX_W-1:0]      bin_a_q, bin_b_q;
	logic [IDX_W:0]        med_sum;

	logic calc_done;
	logic out_free;
	logic start_calc;
	logic finish;

	stats_item_t out_q;
	logic        out_valid_q;

	// input side
	assign cnt_ext  = {1'b0, hist.data.bin_count};
	assign cnt_in   = cnt_ext[COUNT_BITS-1:0];
	assign accept   = hist.valid && hist.ready;
	assign store_en = accept && (next_q < NB_W'(NUM_BINS));
	assign wr_idx   = next_q[IDX_W-1:0];

	// division and median helpers
	assign dvd     = {wsum_q, {MEAN_FRAC_BITS{1'b0}}};
	assign rem_sh  = {rem_q, dvd[div_idx_q]};
	assign q_bit   = (rem_sh >= {1'b0, total_q});
	assign rd_en   = (state_q == ST_CALC) && (rd_cnt_q < next_q);
	assign cum_nxt = cum_q + TC_W'(rd_data_s1);
	assign rank_lo = (total_q - TC_W'(1)) >> 1;
	assign rank_hi = total_q >> 1;
	assign med_sum = {1'b0, bin_a_q} + {1'b0, bin_b_q};

	assign calc_done = div_done_q && (rd_cnt_q == next_q) && !rd_v_s1;
	assign out_free  = !out_valid_q || stats.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (accept && hist.data.last_bin) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_CALC;
			ST_CALC: begin
				if (calc_done) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// controller outputs
	always_comb begin
		hist.ready = 1'b0;
		start_calc = 1'b0;
		finish     = 1'b0;
		case (state_q)
			ST_LOAD:   hist.ready = 1'b1;
			ST_DRAIN:  start_calc = 1'b1;
			ST_CALC:   ;
			ST_FINISH: finish = out_free;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else state_q <= state_d;
	end

	// bin memory
	always_ff @(posedge clk) begin
		if (store_en) mem[wr_idx] <= cnt_in;
		if (rd_en) rd_data_s1 <= mem[rd_cnt_q[IDX_W-1:0]];
	end

	// load pipeline payload
	always_ff @(posedge clk) begin
		cnt_s1  <= cnt_in;
		idx_s1  <= wr_idx;
		prod_s1 <= wr_idx * cnt_in;
	end

	// running totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q     <= '0;
			v_s1       <= 1'b0;
			total_q    <= '0;
			wsum_q     <= '0;
			any_q      <= 1'b0;
			min_q      <= '0;
			max_q      <= '0;
			mode_q     <= '0;
			mode_cnt_q <= '0;
		end else if (finish) begin
			next_q     <= '0;
			v_s1       <= 1'b0;
			total_q    <= '0;
			wsum_q     <= '0;
			any_q      <= 1'b0;
			min_q      <= '0;
			max_q      <= '0;
			mode_q     <= '0;
			mode_cnt_q <= '0;
		end else begin
			v_s1 <= store_en;
			if (store_en) next_q <= next_q + NB_W'(1);
			if (v_s1 && (cnt_s1 != '0)) begin
				total_q <= total_q + TC_W'(cnt_s1);
				wsum_q  <= wsum_q + WS_W'(prod_s1);
				if (!any_q) min_q <= idx_s1;
				any_q <= 1'b1;
				max_q <= idx_s1;
				if (cnt_s1 > mode_cnt_q) begin
					mode_cnt_q <= cnt_s1;
					mode_q     <= idx_s1;
				end
			end
		end
	end

	// mean divider, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_idx_q  <= '0;
			div_done_q <= 1'b0;
			rem_q      <= '0;
			quo_q      <= '0;
		end else if (start_calc) begin
			div_idx_q  <= DI_W'(WD - 1);
			div_done_q <= 1'b0;
			rem_q      <= '0;
			quo_q      <= '0;
		end else if ((state_q == ST_CALC) && !div_done_q) begin
			rem_q <= q_bit ? TC_W'(rem_sh - {1'b0, total_q}) : TC_W'(rem_sh);
			quo_q <= {quo_q[14:0], q_bit};
			if (div_idx_q == '0) div_done_q <= 1'b1;
			else div_idx_q <= div_idx_q - DI_W'(1);
		end
	end

	// median pass over the stored bins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q  <= '0;
			rd_v_s1   <= 1'b0;
			rd_idx_s1 <= '0;
			cum_q     <= '0;
			fa_q      <= 1'b0;
			fb_q      <= 1'b0;
			bin_a_q   <= '0;
			bin_b_q   <= '0;
		end else if (start_calc) begin
			rd_cnt_q <= '0;
			rd_v_s1  <= 1'b0;
			cum_q    <= '0;
			fa_q     <= 1'b0;
			fb_q     <= 1'b0;
			bin_a_q  <= '0;
			bin_b_q  <= '0;
		end else begin
			rd_v_s1   <= rd_en;
			rd_idx_s1 <= rd_cnt_q[IDX_W-1:0];
			if (rd_en) rd_cnt_q <= rd_cnt_q + NB_W'(1);
			if (rd_v_s1) begin
				cum_q <= cum_nxt;
				if (!fa_q && (cum_nxt > rank_lo)) begin
					fa_q    <= 1'b1;
					bin_a_q <= rd_idx_s1;
				end
				if (!fb_q && (cum_nxt > rank_hi)) begin
					fb_q    <= 1'b1;
					bin_b_q <= rd_idx_s1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (stats.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			if (any_q) begin
				out_q.min_value      <= 8'(min_q);
				out_q.max_value      <= 8'(max_q);
				out_q.mean_fixed     <= quo_q;
				out_q.median_doubled <= 9'(med_sum);
				out_q.mode_value     <= 8'(mode_q);
				out_q.empty_res      <= 1'b0;
			end else begin
				out_q           <= '0;
				out_q.empty_res <= 1'b1;
			end
		end
	end

	assign stats.valid = out_valid_q;
	assign stats.data  = out_q;

endmodule

// ===== sim/tb_histogram_statistics.sv =====
// ----------------------------------------------------------------------------
// tb_histogram_statistics
// Self-checking testbench for the histogram statistics block. A table of
// directed histograms (empty, extreme counts, ties, full and overflowing bin
// ranges) is followed by random histograms of mixed length and content. Every
// stats transfer is checked per field against the table's values or, if none, a
// local model of running totals, median pass and fixed-point mean. Both
// channels idle at random, the stats side holds off once for a long stretch,
// and the bin side pauses now and then until every pending result is back.
// ----------------------------------------------------------------------------
module tb_histogram_statistics;
	import hst_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NBINS          = 256;
	localparam logic [30:0] COUNT_MAX      = 31'h7FFF_FFFF;
	localparam int unsigned RANDOM_ITEMS   = 160;
	localparam int unsigned HOLD_CYCLES    = 1000;
	localparam int unsigned SETTLE_CYCLES  = 300;
	localparam int unsigned WATCHDOG_LIMIT = 20000;

	typedef struct {
		logic [30:0] count;
		bit          last;
		int unsigned reps;
		bit          typed;
		stats_item_t want;
	} plan_row_t;

	logic clk;
	logic arst_n;

	hst_stream_if #(.T(bin_item_t))   hist_ch ();
	hst_stream_if #(.T(stats_item_t)) stats_ch ();

	histogram_statistics dut (
		.clk    (clk),
		.arst_n (arst_n),
		.hist   (hist_ch.sink),
		.stats  (stats_ch.source)
	);

	// model state
	logic [30:0] bin_mem [NBINS];
	int unsigned bins_in;
	logic [63:0] total;
	logic [63:0] wsum;
	int unsigned lo_bin;
	int unsigned hi_bin;
	int unsigned mode_idx;
	logic [30:0] mode_cnt;

	stats_item_t stats_expected [$];
	int unsigned fails;
	bit          calm;
	bit          hold_req;

	plan_row_t plan [23] = '{
		'{31'd0,     1'b1, 1,   1'b1, '{8'd0, 8'd0, 16'd0, 9'd0, 8'd0, 1'b1}},
		'{31'd0,     1'b0, 5,   1'b0, '0},
		'{31'd0,     1'b1, 1,   1'b1, '{8'd0, 8'd0, 16'd0, 9'd0, 8'd0, 1'b1}},
		'{COUNT_MAX, 1'b1, 1,   1'b1, '{8'd0, 8'd0, 16'd0, 9'd0, 8'd0, 1'b0}},
		'{31'd0,     1'b0, 1,   1'b0, '0},
		'{31'd5,     1'b1, 1,   1'b1, '{8'd1, 8'd1, 16'd256, 9'd2, 8'd1, 1'b0}},
		'{31'd1,     1'b0, 1,   1'b0, '0},
		'{31'd1,     1'b1, 1,   1'b1, '{8'd0, 8'd1, 16'd128, 9'd1, 8'd0, 1'b0}},
		'{31'd3,     1'b0, 1,   1'b0, '0},
		'{31'd0,     1'b0, 1,   1'b0, '0},
		'{31'd3,     1'b1, 1,   1'b1, '{8'd0, 8'd2, 16'd256, 9'd2, 8'd0, 1'b0}},
		'{31'd0,     1'b0, 255, 1'b0, '0},
		'{COUNT_MAX, 1'b1, 1,   1'b1, '{8'd255, 8'd255, 16'd65280, 9'd510, 8'd255, 1'b0}},
		'{31'd1,     1'b0, 256, 1'b0, '0},
		'{31'd7,     1'b0, 2,   1'b0, '0},
		'{31'd7,     1'b1, 1,   1'b1, '{8'd0, 8'd255, 16'd32640, 9'd255, 8'd0, 1'b0}},
		'{31'h2AAA_AAAA, 1'b0, 1, 1'b0, '0},
		'{31'h5555_5555, 1'b0, 1, 1'b0, '0},
		'{COUNT_MAX, 1'b0, 1,   1'b0, '0},
		'{COUNT_MAX, 1'b1, 1,   1'b0, '0},
		'{31'd2,     1'b0, 1,   1'b0, '0},
		'{31'd0,     1'b0, 2,   1'b0, '0},
		'{31'd1,     1'b1, 1,   1'b0, '0}
	};

	function automatic void clear_totals();
		bins_in  = 0;
		total    = '0;
		wsum     = '0;
		lo_bin   = NBINS;
		hi_bin   = 0;
		mode_idx = 0;
		mode_cnt = '0;
	endfunction

	function automatic int unsigned rank_owner(input logic [63:0] rank);
		logic [63:0] cum;
		cum = '0;
		for (int i = 0; i < bins_in; i++) begin
			cum += bin_mem[i];
			if (cum > rank)
				return i;
		end
		return hi_bin;
	endfunction

	// folds one bin into the totals; returns 1 with the stats on the last bin
	function automatic bit accumulate_bin(input bin_item_t it, output stats_item_t res);
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] mean;
		int unsigned med2;
		res = '0;
		if (bins_in < NBINS) begin
			bin_mem[bins_in] = it.bin_count;
			if (it.bin_count != 0) begin
				total += it.bin_count;
				wsum  += 64'(bins_in) * it.bin_count;
				if (lo_bin == NBINS)
					lo_bin = bins_in;
				hi_bin = bins_in;
				if (it.bin_count > mode_cnt) begin
					mode_cnt = it.bin_count;
					mode_idx = bins_in;
				end
			end
			bins_in++;
		end
		if (!it.last_bin)
			return 1'b0;
		if (total == 0) begin
			res.empty_res = 1'b1;
		end else begin
			q    = wsum / total;
			r    = wsum % total;
			mean = (q << MEAN_FRAC_BITS) + ((r << MEAN_FRAC_BITS) / total);
			if (total[0])
				med2 = 2 * rank_owner((total - 1) / 2);
			else
				med2 = rank_owner(total / 2 - 1) + rank_owner(total / 2);
			res.min_value      = lo_bin[7:0];
			res.max_value      = hi_bin[7:0];
			res.mean_fixed     = mean[15:0];
			res.median_doubled = med2[8:0];
			res.mode_value     = mode_idx[7:0];
		end
		clear_totals();
		return 1'b1;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 120);
	endfunction

	function automatic logic [30:0] pick_count();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return '0;
		if (r < 60)
			return 31'($urandom_range(1, 9));
		if (r < 75)
			return 31'($urandom);
		if (r < 85)
			return COUNT_MAX;
		return 31'($urandom_range(1, 1000));
	endfunction

	function automatic void compare_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			fails++;
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endfunction

	function automatic void check_stats(input stats_item_t got);
		stats_item_t want;
		if (stats_expected.size() == 0) begin
			fails++;
			$display("%0t: unexpected stats transfer, got %p", $time, got);
			return;
		end
		want = stats_expected.pop_front();
		compare_field("min_value", want.min_value, got.min_value);
		compare_field("max_value", want.max_value, got.max_value);
		compare_field("mean_fixed", want.mean_fixed, got.mean_fixed);
		compare_field("median_doubled", want.median_doubled, got.median_doubled);
		compare_field("mode_value", want.mode_value, got.mode_value);
		compare_field("empty_res", want.empty_res, got.empty_res);
	endfunction

	task automatic send_bin(input bin_item_t it, input bit typed, input stats_item_t want);
		stats_item_t res;
		int unsigned gap;
		hist_ch.valid <= 1'b1;
		hist_ch.data  <= it;
		@(posedge clk);
		while (!hist_ch.ready)
			@(posedge clk);
		if (accumulate_bin(it, res))
			stats_expected.push_back(typed ? want : res);
		gap = pick_gap();
		if (gap != 0) begin
			hist_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		hist_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (stats_expected.size() != 0);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// stats side: checks transfers and stalls at random
	initial begin
		int unsigned stall;
		stats_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		stats_ch.ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (stats_ch.valid && stats_ch.ready)
				check_stats(stats_ch.data);
			if (hold_req) begin
				hold_req = 1'b0;
				stats_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				stats_ch.ready <= 1'b1;
			end else begin
				stall = pick_gap();
				if (stall != 0) begin
					stats_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
					stats_ch.ready <= 1'b1;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		int unsigned idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((hist_ch.valid && hist_ch.ready) || (stats_ch.valid && stats_ch.ready))
				idle = 0;
			else
				idle++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		bin_item_t   it;
		int unsigned items;
		int unsigned hist_no;
		int unsigned len;
		int unsigned burst_left;
		int unsigned r;
		bit          zero_hist;

		arst_n        = 1'b0;
		hist_ch.valid = 1'b0;
		hist_ch.data  = '0;
		fails         = 0;
		calm          = 1'b0;
		hold_req      = 1'b0;
		items         = 0;
		hist_no       = 0;
		burst_left    = 0;
		clear_totals();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			for (int k = 1; k <= plan[i].reps; k++) begin
				it.bin_count = plan[i].count;
				it.last_bin  = plan[i].last && (k == plan[i].reps);
				send_bin(it, plan[i].typed, plan[i].want);
			end
		end
		wait_drained();

		while (items < RANDOM_ITEMS) begin
			// long stats stall with a burst of short histograms behind it
			if (hist_no == 3) begin
				hold_req   = 1'b1;
				burst_left = 12;
			end
			if (hist_no % 8 == 7)
				wait_drained();
			r = $urandom_range(0, 99);
			if (burst_left != 0) begin
				burst_left--;
				calm = 1'b1;
				len  = $urandom_range(1, 4);
			end else begin
				calm = ($urandom_range(0, 99) < 15);
				if (r < 70)
					len = $urandom_range(1, 8);
				else if (r < 90)
					len = $urandom_range(9, 40);
				else if (r < 97)
					len = $urandom_range(41, NBINS);
				else
					len = $urandom_range(NBINS + 1, NBINS + 6);
			end
			zero_hist = ($urandom_range(0, 99) < 5);
			for (int j = 0; j < len; j++) begin
				it.bin_count = zero_hist ? 31'd0 : pick_count();
				it.last_bin  = (j == len - 1);
				send_bin(it, 1'b0, '0);
				if (j < NBINS)
					items++;
			end
			hist_no++;
		end
		calm = 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/hst_pkg.sv
rtl/core/hst_stream_if.sv
rtl/core/histogram_statistics.sv
sim/tb_histogram_statistics.sv
